// ===== design/hcbd_pkg.sv =====
// shared constants and types for the chunked body decoder
`default_nettype none

package hcbd_pkg;

  // result error codes
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_SIZE  = 2'd1,
    ERR_LARGE = 2'd2
  } err_t;

  // register word indexes on the configuration port
  localparam logic REG_BODY_LIMIT  = 1'b0;
  localparam logic REG_BODY_LENGTH = 1'b1;

  localparam logic [31:0] BODY_LIMIT_RST  = 32'd1048576;
  localparam logic [31:0] BODY_LENGTH_RST = 32'd0;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // bytes dropped after each chunk's data
  localparam logic [1:0] TRAILER_BYTES = 2'd2;

  // one result word as held in the output stage
  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       done_res;
    err_t       error_code;
  } res_t;

endpackage

`default_nettype wire

// ===== design/hcbd_in_if.sv =====
// input channel: raw body bytes with valid/ready
`default_nettype none

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_request;

  modport source (output valid, output in_byte, output new_request, input ready);
  modport sink (input valid, input in_byte, input new_request, output ready);
endinterface

`default_nettype wire

// ===== design/hcbd_out_if.sv =====
// output channel: decoded payload words with valid/ready
`default_nettype none

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       done_res;
  logic [1:0] error_code;

  modport source (output valid, output out_valid, output out_byte, output done_res,
                  output error_code, input ready);
  modport sink (input valid, input out_valid, input out_byte, input done_res,
                input error_code, output ready);
endinterface

`default_nettype wire

// ===== design/http_chunked_body_decoder.sv =====
// http chunked / content-length body decoder, one byte per word
// throughput: one byte per cycle while the skid register is empty; the decode state updates in a single step per byte
// an output register plus one skid register let input continue while a result waits
// reset (rst, synchronous, active high) clears decode state and the output stage
// and restores the body size limit to 1048576 and the body length to 0
`default_nettype none

module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 31
) (
  input  wire         clk,
  input  wire         rst,
  hcbd_in_if.sink     in_ch,
  hcbd_out_if.source  out_ch,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    PH_SIZE = 3'd0,
    PH_OVF  = 3'd1,
    PH_DATA = 3'd2,
    PH_SKIP = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  // configuration registers
  logic [31:0] body_limit;
  logic [31:0] body_length;

  // decode state
  phase_t                 phase, phase_next;
  logic [SIZE_BITS-1:0]   chunk_remaining, chunk_remaining_next;
  logic [SIZE_BITS-1:0]   size_value, size_value_next;
  logic [31:0]            body_count, body_count_next;
  logic                   saw_digit, saw_digit_next;
  logic                   digits_ended, digits_ended_next;
  logic                   last_was_cr, last_was_cr_next;
  logic [1:0]             skip_count, skip_count_next;
  hcbd_pkg::err_t         error_state, error_state_next;

  // output stage
  hcbd_pkg::res_t out_reg, skid_reg, res_next;
  logic           out_full, skid_full;

  // state as seen by this byte (after an optional restart)
  phase_t               cur_phase;
  logic [SIZE_BITS-1:0] cur_chunk, cur_size;
  logic [31:0]          cur_count;
  logic                 cur_saw, cur_ended, cur_cr;
  logic [1:0]           cur_skip, skip_dec;
  hcbd_pkg::err_t       cur_err;

  logic       in_fire, out_fire, cfg_wr;
  logic [7:0] b;
  logic       is_hex, is_blank, size_ovf, pass;
  logic [3:0] hex_val;

  assign b        = in_ch.in_byte;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_full && out_ch.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // apb side
  assign pready = 1'b1;
  assign prdata = (paddr[2] == hcbd_pkg::REG_BODY_LENGTH) ? body_length : body_limit;

  // handshake and output port
  assign in_ch.ready       = !skid_full;
  assign out_ch.valid      = out_full;
  assign out_ch.out_valid  = out_reg.out_valid;
  assign out_ch.out_byte   = out_reg.out_byte;
  assign out_ch.done_res   = out_reg.done_res;
  assign out_ch.error_code = out_reg.error_code;

  // hex digit and whitespace decode
  always_comb begin
    is_hex  = 1'b0;
    hex_val = 4'd0;
    if (b >= "0" && b <= "9") begin
      is_hex  = 1'b1;
      hex_val = 4'(b - 8'("0"));
    end else if (b >= "a" && b <= "f") begin
      is_hex  = 1'b1;
      hex_val = 4'(b - 8'("a") + 8'd10);
    end else if (b >= "A" && b <= "F") begin
      is_hex  = 1'b1;
      hex_val = 4'(b - 8'("A") + 8'd10);
    end
    is_blank = (b == hcbd_pkg::CH_SPACE) || (b >= hcbd_pkg::CH_TAB && b <= hcbd_pkg::CH_CR);
  end

  // restart view of the state
  always_comb begin
    if (in_ch.new_request) begin
      cur_phase = PH_SIZE;
      cur_chunk = '0;
      cur_size  = '0;
      cur_count = '0;
      cur_saw   = 1'b0;
      cur_ended = 1'b0;
      cur_cr    = 1'b0;
      cur_skip  = '0;
      cur_err   = hcbd_pkg::ERR_NONE;
    end else begin
      cur_phase = phase;
      cur_chunk = chunk_remaining;
      cur_size  = size_value;
      cur_count = body_count;
      cur_saw   = saw_digit;
      cur_ended = digits_ended;
      cur_cr    = last_was_cr;
      cur_skip  = skip_count;
      cur_err   = error_state;
    end
  end

  assign size_ovf = |cur_size[SIZE_BITS-1 -: 4];
  assign skip_dec = (cur_skip != 2'd0) ? cur_skip - 2'd1 : 2'd0;

  // one decode step per byte
  always_comb begin
    phase_next           = cur_phase;
    chunk_remaining_next = cur_chunk;
    size_value_next      = cur_size;
    body_count_next      = cur_count;
    saw_digit_next       = cur_saw;
    digits_ended_next    = cur_ended;
    last_was_cr_next     = cur_cr;
    skip_count_next      = cur_skip;
    error_state_next     = cur_err;
    pass                 = 1'b0;
    if (cur_err == hcbd_pkg::ERR_NONE && cur_phase != PH_DONE) begin
      if (body_length != 32'd0) begin
        // content-length mode: count bytes up to the length
        if (cur_count < body_length) begin
          pass            = 1'b1;
          body_count_next = cur_count + 32'd1;
        end
        if (body_count_next >= body_length) phase_next = PH_DONE;
      end else begin
        unique case (cur_phase) inside
          PH_SIZE, PH_OVF: begin
            if (cur_cr && b == hcbd_pkg::CH_LF) begin
              // end of size line
              if (cur_phase == PH_OVF || !cur_saw) begin
                error_state_next = hcbd_pkg::ERR_SIZE;
              end else if (cur_size == '0) begin
                phase_next = PH_DONE;
              end else begin
                chunk_remaining_next = cur_size;
                phase_next           = PH_DATA;
              end
              size_value_next   = '0;
              saw_digit_next    = 1'b0;
              digits_ended_next = 1'b0;
              last_was_cr_next  = 1'b0;
            end else begin
              last_was_cr_next = (b == hcbd_pkg::CH_CR);
              if (cur_phase == PH_SIZE && !cur_ended) begin
                if (is_hex) begin
                  if (size_ovf) begin
                    phase_next = PH_OVF;
                  end else begin
                    size_value_next = {cur_size[SIZE_BITS-5:0], hex_val};
                    saw_digit_next  = 1'b1;
                  end
                end else if (cur_saw || !is_blank) begin
                  digits_ended_next = 1'b1;
                end
              end
            end
          end
          PH_DATA: begin
            if (cur_chunk == '0) begin
              phase_next      = PH_SKIP;
              skip_count_next = hcbd_pkg::TRAILER_BYTES;
            end else if (cur_count >= body_limit) begin
              error_state_next = hcbd_pkg::ERR_LARGE;
            end else begin
              pass                 = 1'b1;
              body_count_next      = cur_count + 32'd1;
              chunk_remaining_next = cur_chunk - SIZE_BITS'(1);
              if (cur_chunk == SIZE_BITS'(1)) begin
                phase_next      = PH_SKIP;
                skip_count_next = hcbd_pkg::TRAILER_BYTES;
              end
            end
          end
          PH_SKIP: begin
            skip_count_next = skip_dec;
            if (skip_dec == 2'd0) begin
              phase_next       = PH_SIZE;
              last_was_cr_next = 1'b0;
            end
          end
          default: begin
            phase_next = PH_SIZE;
          end
        endcase
      end
    end
    res_next.out_valid  = pass;
    res_next.out_byte   = pass ? b : 8'd0;
    res_next.done_res   = (phase_next == PH_DONE);
    res_next.error_code = error_state_next;
  end

  // state, configuration and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      body_limit      <= hcbd_pkg::BODY_LIMIT_RST;
      body_length     <= hcbd_pkg::BODY_LENGTH_RST;
      phase           <= PH_SIZE;
      chunk_remaining <= '0;
      size_value      <= '0;
      body_count      <= '0;
      saw_digit       <= 1'b0;
      digits_ended    <= 1'b0;
      last_was_cr     <= 1'b0;
      skip_count      <= '0;
      error_state     <= hcbd_pkg::ERR_NONE;
      out_full        <= 1'b0;
      skid_full       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == hcbd_pkg::REG_BODY_LENGTH) body_length <= pwdata;
        else body_limit <= pwdata;
      end
      if (in_fire) begin
        phase           <= phase_next;
        chunk_remaining <= chunk_remaining_next;
        size_value      <= size_value_next;
        body_count      <= body_count_next;
        saw_digit       <= saw_digit_next;
        digits_ended    <= digits_ended_next;
        last_was_cr     <= last_was_cr_next;
        skip_count      <= skip_count_next;
        error_state     <= error_state_next;
      end
      // output register with skid
      if (skid_full) begin
        if (out_fire) begin
          out_reg   <= skid_reg;
          skid_full <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_full || out_fire) begin
          out_reg  <= res_next;
          out_full <= 1'b1;
        end else begin
          skid_reg  <= res_next;
          skid_full <= 1'b1;
        end
      end else if (out_fire) begin
        out_full <= 1'b0;
      end
    end
  end

  // skid word only exists behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_full)
    else $error("skid register full while output register empty");

  // an error sticks until a new request
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    in_fire && !in_ch.new_request && error_state != hcbd_pkg::ERR_NONE
    |=> error_state == $past(error_state))
    else $error("error state changed without a new request");

  // a delivered payload byte never carries an error
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_full && out_reg.out_valid |-> out_reg.error_code == hcbd_pkg::ERR_NONE)
    else $error("payload byte reported together with an error");

  // a full skid stage blocks new input
  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_full && !out_ch.ready |=> !in_fire || !$past(skid_full) || !skid_full)
    else $error("input taken while both output words were held");

endmodule

`default_nettype wire

// ===== tb/http_chunked_body_decoder_tb.sv =====
// self-checking testbench for the http chunked / content-length body decoder
module http_chunked_body_decoder_tb;

  localparam int STALL_LIMIT = 3000;
  localparam logic [34:0] SIZE_LIMIT = (35'd1 << 31) - 35'd1;

  typedef enum logic [2:0] {PH_SIZE, PH_OVF, PH_DATA, PH_SKIP, PH_DONE} dec_phase_t;

  typedef struct {
    logic [7:0] b;
    logic       nr;
  } raw_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hcbd_in_if  in_bus ();
  hcbd_out_if out_bus ();

  http_chunked_body_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // bytes waiting to be offered, and result words waiting to be seen
  raw_byte_t      raw_bytes[$];
  hcbd_pkg::res_t byte_results[$];

  int unsigned num_sent;
  int unsigned num_taken;
  int unsigned num_checked;
  int unsigned fail_count;
  int unsigned stall_cycles;
  int unsigned hold_left;
  logic        hold_done;

  // register copies
  logic [31:0] max_body;
  logic [31:0] content_len;

  // decoder state copy
  dec_phase_t     dec_phase;
  logic [30:0]    chunk_left;
  logic [30:0]    size_acc;
  logic [31:0]    body_count;
  logic           saw_digit;
  logic           digits_ended;
  logic           last_cr;
  logic [1:0]     skip_left;
  hcbd_pkg::err_t dec_err;

  function automatic void clear_decoder();
    dec_phase    = PH_SIZE;
    chunk_left   = '0;
    size_acc     = '0;
    body_count   = '0;
    saw_digit    = 1'b0;
    digits_ended = 1'b0;
    last_cr      = 1'b0;
    skip_left    = '0;
    dec_err      = hcbd_pkg::ERR_NONE;
  endfunction

  // work out the result word for one accepted byte
  function automatic void decode_byte(input logic [7:0] b, input logic nr);
    logic           passed;
    logic           is_hex;
    logic [3:0]     digit;
    logic [34:0]    acc;
    hcbd_pkg::res_t word;
    passed = 1'b0;
    digit = '0;
    if (nr) clear_decoder();
    if (dec_err == hcbd_pkg::ERR_NONE && dec_phase != PH_DONE) begin
      if (content_len != 0) begin
        // content-length body: count is never raised past the length
        if (body_count < content_len) begin
          passed = 1'b1;
          body_count++;
        end
        if (body_count >= content_len) dec_phase = PH_DONE;
      end else if (dec_phase == PH_SIZE || dec_phase == PH_OVF) begin
        if (last_cr && b == hcbd_pkg::CH_LF) begin
          // end of size line
          if (dec_phase == PH_OVF || !saw_digit) begin
            dec_err = hcbd_pkg::ERR_SIZE;
          end else if (size_acc == 0) begin
            dec_phase = PH_DONE;
          end else begin
            chunk_left = size_acc;
            dec_phase = PH_DATA;
          end
          size_acc = '0;
          saw_digit = 1'b0;
          digits_ended = 1'b0;
          last_cr = 1'b0;
        end else begin
          last_cr = (b == hcbd_pkg::CH_CR);
          if (dec_phase == PH_SIZE && !digits_ended) begin
            is_hex = 1'b1;
            if (b >= "0" && b <= "9") digit = 4'(b - "0");
            else if (b >= "a" && b <= "f") digit = 4'(b - "a" + 10);
            else if (b >= "A" && b <= "F") digit = 4'(b - "A" + 10);
            else is_hex = 1'b0;
            if (is_hex) begin
              acc = {size_acc, 4'h0} | {31'd0, digit};
              if (acc > SIZE_LIMIT) begin
                dec_phase = PH_OVF;
              end else begin
                size_acc = acc[30:0];
                saw_digit = 1'b1;
              end
            end else if (saw_digit || !(b == hcbd_pkg::CH_SPACE ||
                         (b >= hcbd_pkg::CH_TAB && b <= hcbd_pkg::CH_CR))) begin
              digits_ended = 1'b1;
            end
          end
        end
      end else if (dec_phase == PH_DATA) begin
        if (chunk_left == 0) begin
          dec_phase = PH_SKIP;
          skip_left = hcbd_pkg::TRAILER_BYTES;
        end
        if (dec_phase == PH_DATA) begin
          if (body_count >= max_body) begin
            dec_err = hcbd_pkg::ERR_LARGE;
          end else begin
            passed = 1'b1;
            body_count++;
            chunk_left--;
            if (chunk_left == 0) begin
              dec_phase = PH_SKIP;
              skip_left = hcbd_pkg::TRAILER_BYTES;
            end
          end
        end
      end else if (dec_phase == PH_SKIP) begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) begin
          dec_phase = PH_SIZE;
          last_cr = 1'b0;
        end
      end else begin
        dec_phase = PH_SIZE;
      end
    end
    word.out_valid  = passed;
    word.out_byte   = passed ? b : 8'h00;
    word.done_res   = (dec_phase == PH_DONE);
    word.error_code = dec_err;
    byte_results.push_back(word);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 40)
      $display("%0t: word %0d %s: got 0x%0h, want 0x%0h", $time, num_checked, what, got, want);
    fail_count++;
  endtask

  // stimulus builders
  function automatic void add_byte(input logic [7:0] b, input logic nr);
    raw_byte_t item;
    item.b = b;
    item.nr = nr;
    raw_bytes.push_back(item);
    num_sent++;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return 8'h30 + 8'(nib);
    return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
  endfunction

  function automatic void add_crlf();
    add_byte(hcbd_pkg::CH_CR, 1'b0);
    add_byte(hcbd_pkg::CH_LF, 1'b0);
  endfunction

  // well-formed size line with random case, padding and extensions
  function automatic void add_size_line(input int unsigned len, input logic first);
    int unsigned n_digits;
    logic        nr;
    nr = first;
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
      add_byte(($urandom_range(0, 1) != 0) ? hcbd_pkg::CH_SPACE : hcbd_pkg::CH_TAB, nr);
      nr = 1'b0;
    end
    n_digits = 1;
    while (n_digits < 8 && (len >> (4 * n_digits)) != 0) n_digits++;
    if ($urandom_range(0, 4) == 0) n_digits++;
    for (int i = int'(n_digits) - 1; i >= 0; i--) begin
      add_byte(hex_char(4'((64'(len) >> (4 * i)) & 64'hF)), nr);
      nr = 1'b0;
    end
    if ($urandom_range(0, 3) == 0) begin
      add_byte(";", 1'b0);
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(8'h67, 8'h7A)), 1'b0);
    end
    add_crlf();
  endfunction

  function automatic void add_chunked_body();
    int unsigned len;
    for (int c = 0; c < int'($urandom_range(1, 3)); c++) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      add_size_line(len, c == 0);
      repeat (len) add_byte(8'($urandom_range(0, 255)), 1'b0);
      // trailer bytes are dropped unchecked
      if ($urandom_range(0, 5) == 0) begin
        add_byte(8'($urandom_range(0, 255)), 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        add_crlf();
      end
    end
    add_size_line(0, 1'b0);
    if ($urandom_range(0, 1) != 0) add_crlf();
  endfunction

  function automatic void add_broken_body();
    int unsigned n;
    case ($urandom_range(0, 3))
      0: begin
        // size line without any digit
        add_byte(hcbd_pkg::CH_SPACE, 1'b1);
        if ($urandom_range(0, 1) != 0) add_byte("g", 1'b0);
        add_crlf();
      end
      1: begin
        // size beyond 31 bits
        n = $urandom_range(8, 9);
        add_byte(hex_char(4'((n == 8) ? $urandom_range(8, 15) : $urandom_range(1, 15))), 1'b1);
        repeat (n - 1) add_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
        add_crlf();
      end
      2: begin
        // raw noise with stray restarts
        add_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat ($urandom_range(4, 16))
          add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 9) == 0));
      end
      default: begin
        // lone cr inside the size line ends the digits
        add_byte("2", 1'b1);
        add_byte(hcbd_pkg::CH_CR, 1'b0);
        add_byte("5", 1'b0);
        add_crlf();
        add_byte(8'($urandom_range(0, 255)), 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b0);
        add_crlf();
      end
    endcase
    repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  function automatic void add_chunked_mix(input int unsigned n);
    int unsigned goal;
    goal = raw_bytes.size() + n;
    while (raw_bytes.size() < goal) begin
      if ($urandom_range(0, 9) < 7) add_chunked_body();
      else add_broken_body();
    end
  endfunction

  function automatic void add_content_bodies(input int unsigned n);
    int unsigned goal;
    goal = raw_bytes.size() + n;
    while (raw_bytes.size() < goal) begin
      add_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endfunction

  // register write over the configuration port, setup then access
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == hcbd_pkg::REG_BODY_LIMIT) max_body = value;
    else content_len = value;
  endtask

  // wait until every byte has been taken and its word checked
  task automatic wait_idle();
    while (num_taken != num_sent || num_checked != num_taken) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin : driver
    raw_byte_t item;
    logic      calm;
    if (rst) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        decode_byte(in_bus.in_byte, in_bus.new_request);
        num_taken++;
      end
      calm = (num_taken >= 100 && num_taken < 250);
      if (!in_bus.valid || in_bus.ready) begin
        if (raw_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 36)) begin
          item = raw_bytes.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.in_byte <= item.b;
          in_bus.new_request <= item.nr;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result word monitor and receiver stalls
  always @(posedge clk) begin : monitor
    hcbd_pkg::res_t want;
    logic           calm;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (byte_results.size() == 0) begin
        report_mismatch("word with nothing expected", {24'd0, out_bus.out_byte}, 32'd0);
      end else begin
        want = byte_results.pop_front();
        if (out_bus.out_valid !== want.out_valid)
          report_mismatch("out_valid", 32'(out_bus.out_valid), 32'(want.out_valid));
        if (out_bus.out_byte !== want.out_byte)
          report_mismatch("out_byte", 32'(out_bus.out_byte), 32'(want.out_byte));
        if (out_bus.done_res !== want.done_res)
          report_mismatch("done_res", 32'(out_bus.done_res), 32'(want.done_res));
        if (out_bus.error_code !== want.error_code)
          report_mismatch("error_code", 32'(out_bus.error_code), 32'(want.error_code));
        num_checked++;
      end
    end
    // one long hold-off so the block fills and stalls its input
    if (!hold_done && num_checked >= 300) begin
      hold_left = 120;
      hold_done = 1'b1;
    end
    calm = (num_checked >= 100 && num_checked < 250);
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm || ($urandom_range(0, 99) >= 36);
    end
  end

  // watchdog on cycles without progress
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", stall_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.in_byte = '0;
    in_bus.new_request = 1'b0;
    out_bus.ready = 1'b0;
    num_sent = 0;
    num_taken = 0;
    num_checked = 0;
    fail_count = 0;
    stall_cycles = 0;
    hold_left = 0;
    hold_done = 1'b0;
    max_body = hcbd_pkg::BODY_LIMIT_RST;
    content_len = hcbd_pkg::BODY_LENGTH_RST;
    clear_decoder();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: blanks, byte extremes, zero chunk, bytes after the end
    add_byte(hcbd_pkg::CH_SPACE, 1'b1);
    add_byte("2", 1'b0);
    add_crlf();
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_crlf();
    add_byte("0", 1'b0);
    add_crlf();
    add_byte("x", 1'b0);
    // empty size line
    add_byte(hcbd_pkg::CH_CR, 1'b1);
    add_byte(hcbd_pkg::CH_LF, 1'b0);
    // size one past the limit, then the largest size
    add_byte("8", 1'b1);
    repeat (7) add_byte("0", 1'b0);
    add_crlf();
    add_byte("7", 1'b1);
    repeat (7) add_byte("F", 1'b0);
    add_crlf();
    add_byte("a", 1'b0);
    add_chunked_mix(150);
    wait_idle();

    // no payload allowed at all
    write_reg(hcbd_pkg::REG_BODY_LIMIT, 32'd0);
    add_chunked_mix(30);
    wait_idle();

    write_reg(hcbd_pkg::REG_BODY_LIMIT, 32'd40);
    add_chunked_mix(100);
    wait_idle();

    write_reg(hcbd_pkg::REG_BODY_LIMIT, 32'hFFFF_FFFF);
    add_chunked_mix(120);
    wait_idle();

    // content length lowered below the bytes already passed
    write_reg(hcbd_pkg::REG_BODY_LENGTH, 32'd5);
    add_byte(8'($urandom_range(0, 255)), 1'b1);
    add_byte(8'($urandom_range(0, 255)), 1'b0);
    add_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_idle();
    write_reg(hcbd_pkg::REG_BODY_LENGTH, 32'd2);
    add_byte(8'($urandom_range(0, 255)), 1'b0);
    add_byte(8'($urandom_range(0, 255)), 1'b0);
    add_content_bodies(60);
    wait_idle();

    write_reg(hcbd_pkg::REG_BODY_LENGTH, 32'hFFFF_FFFF);
    add_content_bodies(50);
    wait_idle();

    write_reg(hcbd_pkg::REG_BODY_LENGTH, 32'd1);
    add_content_bodies(20);
    wait_idle();

    write_reg(hcbd_pkg::REG_BODY_LENGTH, 32'd0);
    write_reg(hcbd_pkg::REG_BODY_LIMIT, hcbd_pkg::BODY_LIMIT_RST);
    add_chunked_mix(100);
    wait_idle();

    repeat (10) @(posedge clk);
    if (byte_results.size() != 0)
      report_mismatch("words never seen", 32'(byte_results.size()), 32'd0);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
